// ===== sv/tppp_pkg.sv =====
package tppp_pkg;

   // field widths
   localparam int OP_W     = 1;
   localparam int SLOT_W   = 8;
   localparam int WORD_W   = 32;
   localparam int INDEX_W  = 8;
   localparam int POS_W    = 10;
   localparam int COLOR_W  = 24;

   // counter widths
   localparam int PIX_W    = 7;
   localparam int COL_W    = 6;
   localparam int DONE_W   = 13;
   localparam int TPR_W    = 7;
   localparam int TC_W     = 14;

   // tile geometry and register limits
   localparam int TILE_PIXELS    = 128;
   localparam int ROW_TILES_MAX  = 64;
   localparam int TILE_COUNT_MAX = 8192;

   // configuration port
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 14;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_TILES_PER_ROW = 1'b0,
      CSR_TILE_COUNT    = 1'b1
   } csr_index_type;

   typedef enum logic [OP_W-1:0] {
      OP_LOAD  = 1'b0,
      OP_PIXEL = 1'b1
   } op_type;

   // position of the current pixel in the linear image
   typedef struct packed {
      logic [POS_W-1:0] x;
      logic [POS_W-1:0] y;
      logic             last;
   } pos_type;

endpackage

// ===== sv/tppp_if.sv =====
interface tppp_req_if;
   import tppp_pkg::*;

   logic                 valid;
   logic                 ready;
   logic [OP_W-1:0]      op;
   logic [SLOT_W-1:0]    palette_slot;
   logic [WORD_W-1:0]    palette_word;
   logic [INDEX_W-1:0]   pixel_index;

   modport source (
      output valid, op, palette_slot, palette_word, pixel_index,
      input  ready
   );

   modport sink (
      input  valid, op, palette_slot, palette_word, pixel_index,
      output ready
   );
endinterface

interface tppp_rsp_if;
   import tppp_pkg::*;

   logic                 valid;
   logic                 ready;
   logic [POS_W-1:0]     pos_x;
   logic [POS_W-1:0]     pos_y;
   logic [COLOR_W-1:0]   color;
   logic                 last_pixel;

   modport source (
      output valid, pos_x, pos_y, color, last_pixel,
      input  ready
   );

   modport sink (
      input  valid, pos_x, pos_y, color, last_pixel,
      output ready
   );
endinterface

// ===== sv/tppp_ram.sv =====
module tppp_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/tppp_walk.sv =====
module tppp_walk #(
   parameter int MAX_TILE_ROWS = 128
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        step,
   input  logic [tppp_pkg::TPR_W-1:0]  tiles_per_row,
   input  logic [tppp_pkg::TC_W-1:0]   tile_count,
   output tppp_pkg::pos_type           pos
);
   import tppp_pkg::*;

   localparam int ROW_W = (MAX_TILE_ROWS > 1) ? $clog2(MAX_TILE_ROWS) : 1;

   logic [PIX_W-1:0]  pixel_ff,  pixel_in;
   logic [COL_W-1:0]  col_ff,    col_in;
   logic [ROW_W-1:0]  row_ff,    row_in;
   logic [DONE_W-1:0] done_ff,   done_in;

   logic [TPR_W-1:0]   row_tiles;
   logic [TC_W-1:0]    count_eff;
   logic               col_end;
   logic               row_end;
   logic               last_tile;
   logic               tile_end;
   logic [ROW_W+2:0]   y_full;
   logic [ROW_W+12:0]  y_wide;

   // clamp the configured sizes to their legal ranges
   always_comb begin
      if (tiles_per_row == '0) begin
         row_tiles = TPR_W'(1);
      end else if (tiles_per_row > TPR_W'(ROW_TILES_MAX)) begin
         row_tiles = TPR_W'(ROW_TILES_MAX);
      end else begin
         row_tiles = tiles_per_row;
      end
      if (tile_count == '0) begin
         count_eff = TC_W'(1);
      end else if (tile_count > TC_W'(TILE_COUNT_MAX)) begin
         count_eff = TC_W'(TILE_COUNT_MAX);
      end else begin
         count_eff = tile_count;
      end
   end

   // end-of-tile, end-of-row and end-of-image flags
   assign tile_end  = (pixel_ff == PIX_W'(TILE_PIXELS - 1));
   assign last_tile = (TC_W'(done_ff) + TC_W'(1)) >= count_eff;
   assign col_end   = (TPR_W'(col_ff) + TPR_W'(1)) >= row_tiles;
   assign row_end   = ((ROW_W+1)'(row_ff) + (ROW_W+1)'(1)) >= (ROW_W+1)'(MAX_TILE_ROWS);

   // linear position from the counters
   assign y_full   = {row_ff, pixel_ff[PIX_W-1:4]};
   assign y_wide   = (ROW_W+13)'(y_full);
   assign pos.x    = {col_ff, pixel_ff[3:0]};
   assign pos.y    = y_wide[POS_W-1:0];
   assign pos.last = last_tile && tile_end;

   // counter advance per placed pixel
   always_comb begin
      pixel_in = pixel_ff;
      col_in   = col_ff;
      row_in   = row_ff;
      done_in  = done_ff;
      if (step) begin
         if (!tile_end) begin
            pixel_in = pixel_ff + PIX_W'(1);
         end else if (last_tile) begin
            pixel_in = '0;
            col_in   = '0;
            row_in   = '0;
            done_in  = '0;
         end else begin
            pixel_in = '0;
            done_in  = done_ff + DONE_W'(1);
            if (col_end) begin
               col_in = '0;
               row_in = row_end ? '0 : row_ff + ROW_W'(1);
            end else begin
               col_in = col_ff + COL_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pixel_ff <= '0;
         col_ff   <= '0;
         row_ff   <= '0;
         done_ff  <= '0;
      end else begin
         pixel_ff <= pixel_in;
         col_ff   <= col_in;
         row_ff   <= row_in;
         done_ff  <= done_in;
      end
   end

endmodule

// ===== sv/tiled_palette_pixel_placer_unit.sv =====
// a pixel word accepted on req passes stage 1 and then the output register to rsp
// throughput: one word per cycle while req_ch.ready is high, loads and pixels alike;
//   the palette ram has one write and one registered read port, so a pixel may follow a load at once
// a stalled rsp holds one result in the output register and one behind it
// reset (synchronous): counters cleared, registers back to one, palette reads zero
module tiled_palette_pixel_placer_unit #(
   parameter int PALETTE_DEPTH = 256,
   parameter int MAX_TILE_ROWS = 128
) (
   input  logic                                  clock,
   input  logic                                  reset,
   tppp_req_if.sink                              req_ch,
   tppp_rsp_if.source                            rsp_ch,
   input  logic                                  csr_we,
   input  logic [tppp_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [tppp_pkg::CSR_DATA_W-1:0]       csr_wdata
);
   import tppp_pkg::*;

   localparam int AW = $clog2(PALETTE_DEPTH);

   logic [TPR_W-1:0] tpr_ff, tpr_in;
   logic [TC_W-1:0]  tc_ff,  tc_in;

   logic             acc;
   logic             pix_acc;
   logic             load_acc;
   logic             slot_ok;
   logic             index_ok;
   logic [COLOR_W-1:0] swapped;
   pos_type          walk_pos;
   logic [COLOR_W-1:0] ram_rdata;

   logic [PALETTE_DEPTH-1:0] pal_valid_ff, pal_valid_in;

   logic             s1_valid_ff, s1_valid_in;
   pos_type          s1_pos_ff;
   logic             s1_hit_ff;
   logic             s1_move;

   logic               out_valid_ff, out_valid_in;
   logic [POS_W-1:0]   out_x_ff;
   logic [POS_W-1:0]   out_y_ff;
   logic [COLOR_W-1:0] out_color_ff;
   logic               out_last_ff;

   // configuration registers
   always_comb begin
      tpr_in = tpr_ff;
      tc_in  = tc_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_TILES_PER_ROW: tpr_in = csr_wdata[TPR_W-1:0];
            CSR_TILE_COUNT:    tc_in  = csr_wdata[TC_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tpr_ff <= TPR_W'(1);
         tc_ff  <= TC_W'(1);
      end else begin
         tpr_ff <= tpr_in;
         tc_ff  <= tc_in;
      end
   end

   // input handshake
   assign s1_move      = !out_valid_ff || rsp_ch.ready;
   assign req_ch.ready = !s1_valid_ff || s1_move;
   assign acc          = req_ch.valid && req_ch.ready;
   assign pix_acc      = acc && (req_ch.op == OP_PIXEL);
   assign load_acc     = acc && (req_ch.op == OP_LOAD);
   assign slot_ok      = {1'b0, req_ch.palette_slot} < (SLOT_W+1)'(PALETTE_DEPTH);
   assign index_ok     = {1'b0, req_ch.pixel_index} < (INDEX_W+1)'(PALETTE_DEPTH);

   // keep bits 23..0 with the outer bytes swapped
   assign swapped = {req_ch.palette_word[7:0], req_ch.palette_word[15:8],
                     req_ch.palette_word[23:16]};

   // palette store
   tppp_ram #(
      .WIDTH (COLOR_W),
      .DEPTH (PALETTE_DEPTH)
   ) u_palette (
      .clock   (clock),
      .wr_en   (load_acc && slot_ok),
      .wr_addr (req_ch.palette_slot[AW-1:0]),
      .wr_data (swapped),
      .rd_en   (pix_acc),
      .rd_addr (req_ch.pixel_index[AW-1:0]),
      .rd_data (ram_rdata)
   );

   // written marks, an unwritten entry reads as zero
   always_comb begin
      pal_valid_in = pal_valid_ff;
      if (load_acc && slot_ok) begin
         pal_valid_in[req_ch.palette_slot[AW-1:0]] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pal_valid_ff <= '0;
      end else begin
         pal_valid_ff <= pal_valid_in;
      end
   end

   // tile walk counters
   tppp_walk #(
      .MAX_TILE_ROWS (MAX_TILE_ROWS)
   ) u_walk (
      .clock         (clock),
      .reset         (reset),
      .step          (pix_acc),
      .tiles_per_row (tpr_ff),
      .tile_count    (tc_ff),
      .pos           (walk_pos)
   );

   // stage 1: wait for the palette read
   assign s1_valid_in = pix_acc || (s1_valid_ff && !s1_move);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pix_acc) begin
         s1_pos_ff <= walk_pos;
         s1_hit_ff <= index_ok && pal_valid_ff[req_ch.pixel_index[AW-1:0]];
      end
   end

   // output register
   assign out_valid_in = (s1_valid_ff && s1_move) || (out_valid_ff && !rsp_ch.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_valid_ff && s1_move) begin
         out_x_ff     <= s1_pos_ff.x;
         out_y_ff     <= s1_pos_ff.y;
         out_color_ff <= s1_hit_ff ? ram_rdata : '0;
         out_last_ff  <= s1_pos_ff.last;
      end
   end

   assign rsp_ch.valid      = out_valid_ff;
   assign rsp_ch.pos_x      = out_x_ff;
   assign rsp_ch.pos_y      = out_y_ff;
   assign rsp_ch.color      = out_color_ff;
   assign rsp_ch.last_pixel = out_last_ff;

`ifndef SYNTH
   // a load never leaves a word in stage 1
   a_load_no_result: assert property (@(posedge clock) disable iff (reset)
      load_acc |=> !s1_valid_ff)
      else $error("load produced a pending result");

   // input stalls only when both stages are full and rsp is blocked
   a_ready_cause: assert property (@(posedge clock) disable iff (reset)
      !req_ch.ready |-> (s1_valid_ff && out_valid_ff && !rsp_ch.ready))
      else $error("input stalled without a full pipeline");

   // a word leaving stage 1 lands in the output register
   a_s1_to_out: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && s1_move) |=> out_valid_ff)
      else $error("result lost between stages");

   // after the last pixel the walk restarts at the origin
   a_walk_restart: assert property (@(posedge clock) disable iff (reset)
      (pix_acc && walk_pos.last) |=> (walk_pos.x == '0 && walk_pos.y == '0))
      else $error("counters did not restart after the last pixel");
`endif

endmodule
